// File: design/sobel_edge_magnitude_rgb_unit_defines.svh
// Assertion macros for the Sobel edge magnitude unit.
// Used by the top level; expects clk and arst_n in scope where expanded.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SEM_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("sobel unit check failed");
// next-cycle implication
`define SEM_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("sobel unit check failed");
`else
`define SEM_ASSERT_IMP(lbl, ante, cons)
`define SEM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies; used by the top level and sem_mag.
package sem_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam logic [10:0] WIDTH_RESET = 11'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;
	localparam int ROW_W = 13;
	localparam logic [20:0] MAG_CLAMP_LIMIT = 21'd65280;
	localparam logic [7:0] MAG_MAX = 8'd255;

	// configuration register indexes
	localparam logic [0:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	// item kinds
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef logic [23:0] pix_t;
	typedef logic [8:0][23:0] win_t;
	typedef logic signed [10:0] grad_t;
	typedef logic [20:0] sqsum_t;

	typedef struct packed {
		logic start;
		logic eof;
	} mag_ctl_t;

	typedef struct packed {
		logic done;
		logic eof;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} mag_res_t;

endpackage

// File: design/sobel_edge_magnitude_rgb_unit.sv
// Sobel edge magnitude unit, RGB, 3x3 window over two line stores.
// Depends on sem_pkg, sem_ram, sem_mag and the assertion macro header.
//
// Takes one frame of RGB pixels in raster order and returns, per channel,
// round(sqrt(Gx^2+Gy^2)) clamped to 255, with off-frame neighbors as zero.
// Results trail the input by one row plus one pixel; after the last pixel,
// send drain items (tuser=1) to push out the rest, one result each; tlast
// marks the frame's final result. One item is worked on at a time: an item
// that gives no result is accepted and decided on, then dropped or moved
// into the window with a line-store read; one that gives a result then also
// passes the square root of sem_mag, which finds one digit per cycle, and a
// result held in the output register by a low tready holds up the next one.
// A drain item that first has to pass the row end takes one extra read
// round. The line stores need no clearing after reset.
`include "sobel_edge_magnitude_rgb_unit_defines.svh"

module sobel_edge_magnitude_rgb_unit #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
	output logic        m_axis_tlast,   // end_of_frame
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = sem_pkg::ROW_W;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_MAG, S_OUT} state_t;

	state_t             state_q;
	logic [10:0]        frame_width_q;
	logic [11:0]        frame_height_q;
	logic [CW-1:0]      ic_q;
	logic [RW-1:0]      ir_q;
	logic               first_q;
	logic               op_q;
	logic               drain_q;
	logic [1:0]         cnt_q;
	sem_pkg::pix_t      pix_q;
	sem_pkg::pix_t      pix_use_q;
	sem_pkg::win_t      win_q;
	sem_pkg::grad_t     gx_q [3];
	sem_pkg::grad_t     gy_q [3];
	sem_pkg::mag_ctl_t  mag_ctl_q;
	sem_pkg::mag_res_t  mag_res;
	logic               out_valid_q;
	logic [23:0]        out_data_q;
	logic               out_last_q;

	logic [WW-1:0]      w_eff;
	logic [11:0]        h_eff;
	logic               rst_first;
	logic [CW-1:0]      ic_c;
	logic [RW-1:0]      ir_c;
	sem_pkg::pix_t      up_rd;
	sem_pkg::pix_t      mid_rd;
	logic               wrap;
	logic               eof_wrap;
	logic               emit_n;
	logic               eof_n;
	logic [CW-1:0]      ic_n;
	logic [RW-1:0]      ir_n;
	sem_pkg::win_t      win1;
	sem_pkg::win_t      win2;
	sem_pkg::win_t      win_e;
	logic [RW-1:0]      erow;
	logic [WW-1:0]      ecol;
	sem_pkg::grad_t     gx_n [3];
	sem_pkg::grad_t     gy_n [3];
	logic               line_we;
	logic               out_load;

	function automatic sem_pkg::win_t win_shift(sem_pkg::win_t w, sem_pkg::pix_t t,
			sem_pkg::pix_t m, sem_pkg::pix_t b);
		sem_pkg::win_t o;
		o[0] = w[1]; o[1] = w[2]; o[2] = t;
		o[3] = w[4]; o[4] = w[5]; o[5] = m;
		o[6] = w[7]; o[7] = w[8]; o[8] = b;
		return o;
	endfunction

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= sem_pkg::WIDTH_RESET;
			frame_height_q <= sem_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sem_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[10:0];
				sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? 12'd1 : frame_height_q;
	end

	// restart check on a fresh item
	assign rst_first = first_q && ((32'(ir_q) > 32'(h_eff) + 1) ||
		(32'(ir_q) == 32'(h_eff) + 1 && ic_q != '0));
	assign ic_c = rst_first ? '0 : ic_q;
	assign ir_c = rst_first ? '0 : ir_q;

	// line stores: upper takes the old middle entry, middle the new pixel
	assign line_we = (state_q == S_READ) && !eof_wrap;

	sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(line_we), .waddr(ic_q), .wdata(mid_rd),
		.raddr(ic_c), .rdata(up_rd)
	);

	sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(line_we), .waddr(ic_q), .wdata(pix_use_q),
		.raddr(ic_c), .rdata(mid_rd)
	);

	// window update, counter advance and emit decision
	always_comb begin
		wrap = (ic_q == '0) && (32'(ir_q) >= 2);
		eof_wrap = wrap && (32'(ir_q) >= 32'(h_eff) + 1);
		win1 = wrap ? win_shift(win_q, '0, '0, '0) : win_q;
		win2 = win_shift(win1, up_rd, mid_rd, pix_use_q);
		if (32'(ic_q) + 1 >= 32'(w_eff)) begin
			ic_n = '0;
			ir_n = ir_q + RW'(1);
		end else begin
			ic_n = ic_q + CW'(1);
			ir_n = ir_q;
		end
		emit_n = wrap || (ic_q != '0 && ir_q != '0);
		if (wrap) begin
			win_e = win1;
			erow = ir_q - RW'(2);
			ecol = w_eff - WW'(1);
			eof_n = eof_wrap;
		end else begin
			win_e = win2;
			erow = ir_q - RW'(1);
			ecol = WW'(ic_q) - WW'(1);
			eof_n = (32'(ir_q) >= 32'(h_eff)) && (32'(ic_q) >= 32'(w_eff));
		end
	end

	// masked Sobel gradients per channel, red first
	always_comb begin
		logic signed [10:0] p [9];
		logic top, bot, lft, rgt, off;
		int r, c;
		top = (erow == '0);
		bot = (32'(erow) + 1 >= 32'(h_eff));
		lft = (ecol == '0);
		rgt = (32'(ecol) + 1 >= 32'(w_eff));
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				r = (i >= 6) ? 2 : ((i >= 3) ? 1 : 0);
				c = i - 3 * r;
				off = (r == 0 && top) || (r == 2 && bot) || (c == 0 && lft) ||
					(c == 2 && rgt);
				p[i] = off ? 11'sd0 : $signed({3'b000, win_e[i][16 - 8 * ch +: 8]});
			end
			gx_n[ch] = (p[2] + 11'sd2 * p[5] + p[8]) - (p[0] + 11'sd2 * p[3] + p[6]);
			gy_n[ch] = (p[6] + 11'sd2 * p[7] + p[8]) - (p[0] + 11'sd2 * p[1] + p[2]);
		end
	end

	sem_mag u_mag (
		.clk(clk), .arst_n(arst_n), .ctl(mag_ctl_q),
		.gx(gx_q), .gy(gy_q), .res(mag_res)
	);

	assign out_load = ((state_q == S_MAG && mag_res.done) || state_q == S_OUT) &&
		(!out_valid_q || m_axis_tready);

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ic_q <= '0;
			ir_q <= '0;
			first_q <= 1'b0;
			drain_q <= 1'b0;
			cnt_q <= '0;
			win_q <= '0;
			mag_ctl_q <= '0;
		end else begin
			mag_ctl_q.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tuser;
						// hold red in the top byte, blue in the bottom byte
						pix_q <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
						first_q <= 1'b1;
						cnt_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					ic_q <= ic_c;
					ir_q <= ir_c;
					first_q <= 1'b0;
					if (32'(ir_c) < 32'(h_eff)) begin
						if (!first_q || op_q == sem_pkg::OP_DRAIN) begin
							state_q <= S_IDLE;
						end else begin
							pix_use_q <= pix_q;
							drain_q <= 1'b0;
							state_q <= S_READ;
						end
					end else if (32'(ir_c) > 32'(h_eff) + 1) begin
						state_q <= S_IDLE;
					end else if (32'(ir_c) == 32'(h_eff) + 1 && ic_c != '0) begin
						// past the drain phase: drop the frame
						ic_q <= '0;
						ir_q <= '0;
						state_q <= S_IDLE;
					end else if (cnt_q == 2'd3) begin
						state_q <= S_IDLE;
					end else begin
						pix_use_q <= '0;
						drain_q <= 1'b1;
						cnt_q <= cnt_q + 2'd1;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					win_q <= eof_wrap ? win1 : win2;
					if (emit_n && eof_n) begin
						ic_q <= '0;
						ir_q <= '0;
					end else begin
						ic_q <= ic_n;
						ir_q <= ir_n;
					end
					if (emit_n) begin
						gx_q <= gx_n;
						gy_q <= gy_n;
						mag_ctl_q.start <= 1'b1;
						mag_ctl_q.eof <= eof_n;
						state_q <= S_MAG;
					end else begin
						state_q <= drain_q ? S_CHECK : S_IDLE;
					end
				end
				S_MAG: begin
					if (mag_res.done) begin
						state_q <= out_load ? S_IDLE : S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register: load a finished result, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_data_q <= {mag_res.blue, mag_res.green, mag_res.red};
			out_last_q <= mag_res.eof;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	`SEM_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`SEM_ASSERT_IMP(a_done_in_wait, mag_res.done, state_q == S_MAG)
	`SEM_ASSERT_NXT(a_eof_restart, out_load && mag_res.eof, ic_q == '0 && ir_q == '0)

endmodule

// File: design/sem_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/sem_mag.sv
// Per-channel gradient magnitude: squares, 8-step square root, rounding.
// Depends on sem_pkg.
module sem_mag (
	input  logic                clk,
	input  logic                arst_n,
	input  sem_pkg::mag_ctl_t   ctl,
	input  sem_pkg::grad_t      gx [3],
	input  sem_pkg::grad_t      gy [3],
	output sem_pkg::mag_res_t   res
);

	typedef enum logic [1:0] {M_IDLE, M_SQ, M_ROOT, M_RND} mstate_t;

	mstate_t          state_q;
	logic [7:0]       bit_q;
	logic             eof_q;
	sem_pkg::sqsum_t  s_q [3];
	logic [7:0]       n_q [3];
	logic [7:0]       n_nx [3];
	logic [7:0]       rnd [3];

	// one root digit per cycle, and final rounding
	always_comb begin
		logic [7:0]  t;
		logic [15:0] tt;
		logic [16:0] nn;
		logic [8:0]  r;
		for (int c = 0; c < 3; c++) begin
			t = n_q[c] | bit_q;
			tt = 16'(t) * 16'(t);
			n_nx[c] = (21'(tt) <= s_q[c]) ? t : n_q[c];
			nn = 17'(16'(n_q[c]) * 16'(n_q[c])) + 17'(n_q[c]);
			r = 9'(n_q[c]) + ((s_q[c] > 21'(nn)) ? 9'd1 : 9'd0);
			if (s_q[c] > sem_pkg::MAG_CLAMP_LIMIT || r[8]) begin
				rnd[c] = sem_pkg::MAG_MAX;
			end else begin
				rnd[c] = r[7:0];
			end
		end
	end

	// sequence squares, root steps and rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			res.done <= 1'b0;
			bit_q <= '0;
		end else begin
			res.done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (ctl.start) begin
						eof_q <= ctl.eof;
						state_q <= M_SQ;
					end
				end
				M_SQ: begin
					for (int c = 0; c < 3; c++) begin
						s_q[c] <= 21'(22'(gx[c] * gx[c])) + 21'(22'(gy[c] * gy[c]));
						n_q[c] <= '0;
					end
					bit_q <= 8'h80;
					state_q <= M_ROOT;
				end
				M_ROOT: begin
					for (int c = 0; c < 3; c++) begin
						n_q[c] <= n_nx[c];
					end
					bit_q <= bit_q >> 1;
					if (bit_q[0]) begin
						state_q <= M_RND;
					end
				end
				M_RND: begin
					res.red <= rnd[0];
					res.green <= rnd[1];
					res.blue <= rnd[2];
					res.eof <= eof_q;
					res.done <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

// File: bench/tb_sobel_edge_magnitude_rgb_unit.sv
// Self-checking bench for the RGB Sobel edge magnitude unit.
// Needs sem_pkg and sobel_edge_magnitude_rgb_unit; an internal predictor holds the expected results.
module tb_sobel_edge_magnitude_rgb_unit;

	localparam int LINE_DEPTH = 1024;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1050;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       eof;
	} edge_res_t;

	// Line-buffer Sobel predictor and the queue of expected magnitudes.
	class edge_scoreboard;
		logic [23:0] upper_line[LINE_DEPTH];
		logic [23:0] middle_line[LINE_DEPTH];
		logic [23:0] window[9];
		int unsigned in_col, in_row;
		int unsigned width_reg, height_reg;
		edge_res_t expected_mags[$];
		int errors;

		function new();
			for (int i = 0; i < LINE_DEPTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 9; i++) window[i] = '0;
			in_col = 0;
			in_row = 0;
			width_reg = 32'(sem_pkg::WIDTH_RESET);
			height_reg = 32'(sem_pkg::HEIGHT_RESET);
			errors = 0;
		endfunction

		function int unsigned cur_width();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned cur_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_reg(logic [0:0] idx, logic [11:0] val);
			if (idx == sem_pkg::REG_FRAME_WIDTH) width_reg = 32'(val[10:0]);
			if (idx == sem_pkg::REG_FRAME_HEIGHT) height_reg = 32'(val);
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
		endfunction

		function void shift_window(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
			logic [23:0] col[3];
			col[0] = top;
			col[1] = mid;
			col[2] = bot;
			for (int r = 0; r < 3; r++) begin
				window[r*3] = window[r*3+1];
				window[r*3+1] = window[r*3+2];
				window[r*3+2] = col[r];
			end
		endfunction

		// rounded square root, saturated at 255
		function logic [7:0] root_round(int unsigned s);
			int unsigned n;
			int unsigned t;
			if (s > sem_pkg::MAG_CLAMP_LIMIT) return sem_pkg::MAG_MAX;
			n = 0;
			for (int b = 7; b >= 0; b--) begin
				t = n | (1 << b);
				if (t * t <= s) n = t;
			end
			if (s > n * n + n) n++;
			return (n > 255) ? sem_pkg::MAG_MAX : n[7:0];
		endfunction

		function edge_res_t gradient_at(int unsigned row, int unsigned col,
				int unsigned w, int unsigned h);
			edge_res_t res;
			int p[9];
			int gx, gy;
			int r, c;
			bit off;
			logic [7:0] m[3];
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 9; i++) begin
					r = i / 3;
					c = i % 3;
					off = (r == 0 && row == 0) || (r == 2 && row + 1 >= h) ||
						(c == 0 && col == 0) || (c == 2 && col + 1 >= w);
					p[i] = off ? 0 : int'((window[i] >> (16 - 8 * ch)) & 24'hFF);
				end
				gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
				gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
				m[ch] = root_round(32'(gx * gx + gy * gy));
			end
			res.red = m[0];
			res.green = m[1];
			res.blue = m[2];
			res.eof = (row + 1 >= h) && (col + 1 >= w);
			if (res.eof) restart();
			return res;
		endfunction

		// push one pixel through the window; returns 1 when a result falls out
		function bit push_pixel(logic [23:0] pix);
			int unsigned w, h, ir, ic, idx;
			edge_res_t res;
			w = cur_width();
			h = cur_height();
			ir = in_row;
			ic = in_col;
			idx = (ic < LINE_DEPTH) ? ic : LINE_DEPTH - 1;
			if (ic == 0 && ir >= 2) begin
				shift_window('0, '0, '0);
				res = gradient_at(ir - 2, w - 1, w, h);
				expected_mags.push_back(res);
				if (res.eof) return 1;
				shift_window(upper_line[idx], middle_line[idx], pix);
				upper_line[idx] = middle_line[idx];
				middle_line[idx] = pix;
				if (ic + 1 >= w) begin
					in_col = 0;
					in_row = ir + 1;
				end else begin
					in_col = ic + 1;
				end
				return 1;
			end
			shift_window(upper_line[idx], middle_line[idx], pix);
			upper_line[idx] = middle_line[idx];
			middle_line[idx] = pix;
			if (ic + 1 >= w) begin
				in_col = 0;
				in_row = ir + 1;
			end else begin
				in_col = ic + 1;
			end
			if (ic >= 1 && ir >= 1) begin
				expected_mags.push_back(gradient_at(ir - 1, ic - 1, w, h));
				return 1;
			end
			return 0;
		endfunction

		// note an accepted input transfer
		function void note_input(logic op, logic [23:0] data);
			int unsigned h;
			h = cur_height();
			if (in_row > h + 1 || (in_row == h + 1 && in_col != 0)) restart();
			if (in_row < h) begin
				if (op == sem_pkg::OP_DRAIN) return;
				// stored as red, green, blue from the top byte down
				void'(push_pixel({data[7:0], data[15:8], data[23:16]}));
				return;
			end
			for (int k = 0; k < 3; k++) begin
				if (in_row < h || in_row > h + 1) return;
				if (in_row == h + 1 && in_col != 0) begin
					restart();
					return;
				end
				if (push_pixel('0)) return;
			end
		endfunction

		// compare one output transfer with the oldest expectation
		function void check_result(logic [23:0] data, logic last);
			edge_res_t e;
			if (expected_mags.size() == 0) begin
				$display("%0t: unexpected result data=%h last=%b", $time, data, last);
				errors++;
				return;
			end
			e = expected_mags.pop_front();
			if (data[7:0] !== e.red)
				$display("%0t: red expected %0d actual %0d", $time, e.red, data[7:0]);
			if (data[15:8] !== e.green)
				$display("%0t: green expected %0d actual %0d", $time, e.green, data[15:8]);
			if (data[23:16] !== e.blue)
				$display("%0t: blue expected %0d actual %0d", $time, e.blue, data[23:16]);
			if (last !== e.eof)
				$display("%0t: end_of_frame expected %b actual %b", $time, e.eof, last);
			if (data !== {e.blue, e.green, e.red} || last !== e.eof) errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // in_red, in_green, in_blue
	logic        s_axis_tuser;   // op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // out_red, out_green, out_blue
	logic        m_axis_tlast;   // end_of_frame
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [11:0] cfg_data;

	edge_scoreboard sb = new();
	int items_sent;
	int results_seen;
	int cycle_count;
	int idle_cycles;
	bit calm;

	sobel_edge_magnitude_rgb_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// offer one item; optionally drop valid for a short burst first
	task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0 && (cycle_count / 400) % 3 != 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {b, g, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(op, s_axis_tdata);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixel_rand(int bias);
		logic [7:0] ch[3];
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) < bias) ch[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else ch[i] = 8'($urandom_range(0, 255));
		end
		send_item(sem_pkg::OP_PIXEL, ch[0], ch[1], ch[2]);
	endtask

	// hold the sender until every expected result is out, then let the block settle
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (sb.expected_mags.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [11:0] val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic run_frame(int unsigned w, int unsigned h, int bias);
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'(w));
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'(h));
		for (int i = 0; i < w * h; i++) send_pixel_rand(bias);
		// drain, sometimes with stray pixels that act as drains
		for (int i = 0; i <= w; i++) begin
			if ($urandom_range(0, 5) == 0) send_pixel_rand(0);
			else send_item(sem_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// result side: random ready bursts, one long hold-off
	initial begin
		int gap;
		bit held;
		m_axis_tready = 1'b0;
		gap = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 40) begin
				held = 1;
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
			end
			if (gap > 0) begin
				gap--;
				m_axis_tready = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0 && (cycle_count / 300) % 3 != 1) begin
				gap = $urandom_range(0, 5);
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tlast);
				results_seen++;
			end
		end
	end

	initial begin
		int unsigned w, h;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = sem_pkg::OP_PIXEL;
		cfg_we = 1'b0;
		cfg_index = sem_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		items_sent = 0;
		results_seen = 0;
		cycle_count = 0;
		idle_cycles = 0;
		calm = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// drain with nothing pending under the reset geometry
		send_item(sem_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);

		// small frame at full contrast, stray pixel in the drain and a drain between frames
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd3);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd3);
		for (int i = 0; i < 9; i++) begin
			if (i % 2 == 0) send_item(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
			else send_item(sem_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
		end
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(sem_pkg::OP_PIXEL, 8'h5A, 8'hA5, 8'h3C);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);

		// shrink the height past the input position: frame is dropped
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd4);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd8);
		for (int i = 0; i < 9; i++) send_pixel_rand(2);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd1);

		// zero width and height act as one
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd0);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd0);
		send_item(sem_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h80);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);

		// tallest height, then change it mid-frame before any result
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'd1);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'hFFF);
		send_pixel_rand(2);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd2);
		send_pixel_rand(2);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);

		// widest register value; the open row carries into the next frame setup
		write_reg(sem_pkg::REG_FRAME_WIDTH, 12'h7FF);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 12'd1);
		for (int i = 0; i < 3; i++) send_pixel_rand(1);
		send_item(sem_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);

		// random frames, mostly small
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > RANDOM_ITEMS - 150) calm = 1;
			if ($urandom_range(0, 9) == 0) w = $urandom_range(1, 40);
			else w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			run_frame(w, h, $urandom_range(0, 2));
			// noise between frames
			if ($urandom_range(0, 3) == 0)
				send_item(sem_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		end

		s_axis_tvalid = 1'b0;
		while (sb.expected_mags.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && !m_axis_tvalid) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
